// ===== hdl/pgl_pkg.sv =====
// ----------------------------------------------------------------------------
// pgl_pkg
// Shared types, constants and control structs for the pad grid line centroid.
// ----------------------------------------------------------------------------
package pgl_pkg;

    localparam int PADS_Z_DEF      = 36;
    localparam int PADS_Y_DEF      = 32;
    localparam int MODULES_ROW_DEF = 4;
    localparam int MODULE_ROWS_DEF = 2;

    localparam int SUM_W   = 40;
    localparam int COUNT_W = 16;
    localparam int COORD_W = 24;
    localparam int ACC_W   = 64;
    localparam int N_W     = 32;
    localparam int DIV_W   = 64;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DV_W    = 16;
    localparam int NUM_AXES = 3;

    localparam logic [COORD_W-1:0] MAX24 = '1;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_BY_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_VELOCITY   = 1'd1;

    localparam logic            GROUP_RESET = 1'b1;
    localparam logic [DV_W-1:0] DV_RESET    = 16'd5249;

    typedef struct packed {
        logic [1:0]                command;
        logic [3:0]                module_req;
        logic [5:0]                pad_z_local;
        logic [5:0]                pad_y_local;
        logic signed [COORD_W-1:0] coord_z;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_t;
        logic [7:0]                line_index;
    } in_word_t;

    typedef struct packed {
        logic [7:0]                line_number;
        logic [COORD_W-1:0]        hit_total;
        logic                      has_hits;
        logic signed [COORD_W-1:0] mean_z;
        logic signed [COORD_W-1:0] mean_y;
        logic signed [COORD_W-1:0] mean_t;
        logic [COORD_W-1:0]        error_z;
        logic [COORD_W-1:0]        error_y;
        logic [COORD_W-1:0]        error_t;
        logic signed [COORD_W-1:0] drift_position;
        logic [COORD_W-1:0]        drift_error;
        logic                      single_hit;
    } out_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_z;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_t;
        logic [COUNT_W-1:0]      count;
    } pad_entry_t;

    typedef enum logic [1:0] {
        DIV_MEAN = 2'd0,
        DIV_PAD  = 2'd1,
        DIV_ERR  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     rd_hit;
        logic     wr_hit;
        logic     clr_wr;
        logic     rd_line;
        logic     p1_acc;
        logic     step_line;
        logic     k_clr;
        logic     k_inc;
        logic     div_start;
        div_sel_t div_sel;
        logic     md_latch;
        logic     p2_diff;
        logic     p2_sqr;
        logic     p2_acc;
        logic     nn_calc;
        logic     sq_start;
        logic     err_latch;
        logic     drift_calc;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic line_ok;
        logic pad_last;
        logic sweep_last;
        logic k_last;
        logic n_zero;
        logic n_one;
        logic pad_empty;
        logic div_done;
        logic sqrt_done;
    } dp_stat_t;

endpackage

// ===== hdl/pgl_div.sv =====
// ----------------------------------------------------------------------------
// pgl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgl_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pgl_pkg::DIV_W-1:0]  num,
    input  logic [pgl_pkg::DIV_W-1:0]  den,
    output logic                       done,
    output logic [pgl_pkg::DIV_W-1:0]  quo
);
    localparam int W  = pgl_pkg::DIV_W;
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/pgl_sqrt.sv =====
// ----------------------------------------------------------------------------
// pgl_sqrt
// Bitwise integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pgl_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pgl_pkg::DIV_W-1:0]   val,
    output logic                        done,
    output logic [pgl_pkg::DIV_W/2-1:0] root
);
    localparam int W  = pgl_pkg::DIV_W;
    localparam int CW = $clog2(W / 2);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  res_reg;
    logic [W-1:0]  bit_reg;
    logic [W-1:0]  trial;
    logic          ge;

    always_comb begin
        trial = res_reg + bit_reg;
        ge    = x_reg >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= val;
                res_reg  <= '0;
                bit_reg  <= {2'b01, {(W-2){1'b0}}};
            end else if (busy_reg) begin
                x_reg   <= ge ? x_reg - trial : x_reg;
                res_reg <= ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W / 2 - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[W/2-1:0];

endmodule

// ===== hdl/pgl_dpath.sv =====
// ----------------------------------------------------------------------------
// pgl_dpath
// Pad memory, line accumulators, shared divider and root unit, result word.
// ----------------------------------------------------------------------------
module pgl_dpath #(
    parameter int PADS_Z_PER_MODULE = pgl_pkg::PADS_Z_DEF,
    parameter int PADS_Y_PER_MODULE = pgl_pkg::PADS_Y_DEF,
    parameter int MODULES_PER_ROW   = pgl_pkg::MODULES_ROW_DEF,
    parameter int MODULE_ROWS       = pgl_pkg::MODULE_ROWS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pgl_pkg::in_word_t                s_word,
    input  logic                             cfg_wr_en,
    input  logic [pgl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pgl_pkg::DV_W-1:0]         cfg_wr_data,
    input  pgl_pkg::dp_cmd_t                 cmd,
    output pgl_pkg::dp_stat_t                stat,
    output pgl_pkg::out_word_t               m_word
);
    localparam int GRID_Z    = PADS_Z_PER_MODULE * MODULES_PER_ROW;
    localparam int GRID_Y    = PADS_Y_PER_MODULE * MODULE_ROWS;
    localparam int GRID_PADS = GRID_Z * GRID_Y;
    localparam int NUM_MODS  = MODULES_PER_ROW * MODULE_ROWS;
    localparam int AW        = (GRID_PADS > 1) ? $clog2(GRID_PADS) : 1;
    localparam int ACC_W     = pgl_pkg::ACC_W;
    localparam int N_W       = pgl_pkg::N_W;
    localparam int DW        = pgl_pkg::DIV_W;
    localparam int CW        = pgl_pkg::COORD_W;
    localparam int DFW       = pgl_pkg::DIFF_W;
    localparam int PW        = CW + pgl_pkg::DV_W;

    logic                        group_reg;
    logic [pgl_pkg::DV_W-1:0]    dv_reg;

    pgl_pkg::pad_entry_t         pad_mem [GRID_PADS];
    pgl_pkg::pad_entry_t         rd_q_reg;
    pgl_pkg::pad_entry_t         wr_data;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic                        mem_we;
    logic                        mem_re;

    logic [AW-1:0]               cnt_reg;
    logic [1:0]                  k_reg;
    logic [7:0]                  line_reg;
    logic signed [CW-1:0]        cz_reg, cy_reg, ct_reg;
    logic [AW-1:0]               hit_addr_reg;
    logic                        hit_ok_reg;
    logic [AW-1:0]               hit_addr;
    logic                        hit_ok;
    logic [3:0]                  mod_row;
    logic [3:0]                  mod_col;

    logic [AW-1:0]               line_addr;
    int                          line_len;
    int                          line_lim;

    logic [N_W-1:0]              n_reg;
    logic signed [ACC_W-1:0]     lsum_reg [pgl_pkg::NUM_AXES];
    logic [ACC_W-1:0]            ss_reg   [pgl_pkg::NUM_AXES];
    logic signed [CW-1:0]        mean_reg [pgl_pkg::NUM_AXES];
    logic [CW-1:0]               err_reg  [pgl_pkg::NUM_AXES];
    logic signed [DFW-1:0]       d_reg;
    logic [2*DFW-1:0]            sq_reg;
    logic [2*N_W-1:0]            nn_reg;
    logic [PW-1:0]               dp_prod_reg;
    logic [PW-1:0]               de_prod_reg;

    logic [DW-1:0]               div_num, div_den, div_quo;
    logic                        div_neg, div_neg_reg, div_done;
    logic signed [ACC_W-1:0]     div_src;
    logic [DW-1:0]               div_mag;
    logic [DW/2-1:0]             root;
    logic                        sqrt_done;
    logic signed [CW-1:0]        q_round;
    logic [N_W-1:0]              n_m1;
    logic [CW-1:0]               mt_mag;
    logic [PW-1:0]               dp_sum, de_sum;
    logic [CW-1:0]               dp_mag;
    pgl_pkg::out_word_t          out_next;
    pgl_pkg::out_word_t          m_word_reg;

    function automatic logic signed [CW-1:0] round_clamp(input logic [DW-1:0] q,
                                                         input logic neg);
        logic signed [CW-1:0] r;
        if (neg) begin
            if (q >= DW'(24'h800000)) r = 24'sh800000;
            else r = -$signed(q[CW-1:0]);
        end else begin
            if (q > DW'(24'h7FFFFF)) r = 24'sh7FFFFF;
            else r = $signed(q[CW-1:0]);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg <= pgl_pkg::GROUP_RESET;
            dv_reg    <= pgl_pkg::DV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pgl_pkg::REG_GROUP_BY_COLUMNS: group_reg <= cfg_wr_data[0];
                pgl_pkg::REG_DRIFT_VELOCITY:   dv_reg    <= cfg_wr_data;
            endcase
        end
    end

    always_comb begin
        mod_row = '0;
        for (int r = 1; r < MODULE_ROWS; r++) begin
            if (32'(s_word.module_req) >= r * MODULES_PER_ROW) mod_row = 4'(r);
        end
        mod_col  = s_word.module_req - 4'(32'(mod_row) * MODULES_PER_ROW);
        hit_ok   = (32'(s_word.module_req) < NUM_MODS)
                && (32'(s_word.pad_z_local) < PADS_Z_PER_MODULE)
                && (32'(s_word.pad_y_local) < PADS_Y_PER_MODULE);
        hit_addr = AW'((32'(mod_col) * PADS_Z_PER_MODULE + 32'(s_word.pad_z_local)) * GRID_Y
                     + 32'(mod_row) * PADS_Y_PER_MODULE + 32'(s_word.pad_y_local));
    end

    always_comb begin
        line_len  = group_reg ? GRID_Y : GRID_Z;
        line_lim  = group_reg ? GRID_Z : GRID_Y;
        line_addr = group_reg ? AW'(32'(line_reg) * GRID_Y + 32'(cnt_reg))
                              : AW'(32'(cnt_reg) * GRID_Y + 32'(line_reg));
    end

    always_comb begin
        mem_re  = cmd.rd_hit | cmd.rd_line;
        rd_addr = cmd.rd_hit ? hit_addr : line_addr;
        mem_we  = cmd.clr_wr
                | (cmd.wr_hit & hit_ok_reg & (rd_q_reg.count != '1));
        wr_addr = cmd.clr_wr ? cnt_reg : hit_addr_reg;
        if (cmd.clr_wr) begin
            wr_data = '0;
        end else begin
            wr_data.sum_z = rd_q_reg.sum_z + pgl_pkg::SUM_W'(cz_reg);
            wr_data.sum_y = rd_q_reg.sum_y + pgl_pkg::SUM_W'(cy_reg);
            wr_data.sum_t = rd_q_reg.sum_t + pgl_pkg::SUM_W'(ct_reg);
            wr_data.count = rd_q_reg.count + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) pad_mem[wr_addr] <= wr_data;
        if (mem_re) rd_q_reg <= pad_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            k_reg   <= '0;
        end else begin
            if (cmd.capture) begin
                cnt_reg <= '0;
            end else if (cmd.clr_wr) begin
                cnt_reg <= stat.sweep_last ? '0 : cnt_reg + 1'b1;
            end else if (cmd.step_line) begin
                cnt_reg <= stat.pad_last ? '0 : cnt_reg + 1'b1;
            end
            if (cmd.capture || cmd.k_clr) k_reg <= '0;
            else if (cmd.k_inc) k_reg <= k_reg + 1'b1;
        end
    end

    always_comb begin
        case (cmd.div_sel)
            pgl_pkg::DIV_MEAN: begin
                div_src = lsum_reg[k_reg];
                div_den = DW'(n_reg);
            end
            pgl_pkg::DIV_PAD: begin
                case (k_reg)
                    2'd0:    div_src = ACC_W'(rd_q_reg.sum_z);
                    2'd1:    div_src = ACC_W'(rd_q_reg.sum_y);
                    default: div_src = ACC_W'(rd_q_reg.sum_t);
                endcase
                div_den = DW'(rd_q_reg.count);
            end
            default: begin
                div_src = $signed(ss_reg[k_reg]);
                div_den = DW'(nn_reg);
            end
        endcase
        if (cmd.div_sel == pgl_pkg::DIV_ERR) begin
            div_neg = 1'b0;
            div_mag = ss_reg[k_reg];
            div_num = div_mag;
        end else begin
            div_neg = div_src[ACC_W-1];
            div_mag = div_neg ? DW'(-div_src) : DW'(div_src);
            div_num = div_mag + (div_den >> 1);
        end
        q_round = round_clamp(div_quo, div_neg_reg);
        n_m1    = n_reg - 1'b1;
    end

    pgl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    pgl_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sq_start),
        .val     (div_quo),
        .done    (sqrt_done),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            line_reg     <= s_word.line_index;
            cz_reg       <= s_word.coord_z;
            cy_reg       <= s_word.coord_y;
            ct_reg       <= s_word.coord_t;
            hit_addr_reg <= hit_addr;
            hit_ok_reg   <= hit_ok;
            n_reg        <= '0;
            for (int a = 0; a < pgl_pkg::NUM_AXES; a++) begin
                lsum_reg[a] <= '0;
                ss_reg[a]   <= '0;
            end
        end
        if (cmd.p1_acc) begin
            n_reg       <= n_reg + N_W'(rd_q_reg.count);
            lsum_reg[0] <= lsum_reg[0] + ACC_W'(rd_q_reg.sum_z);
            lsum_reg[1] <= lsum_reg[1] + ACC_W'(rd_q_reg.sum_y);
            lsum_reg[2] <= lsum_reg[2] + ACC_W'(rd_q_reg.sum_t);
        end
        if (cmd.div_start) div_neg_reg <= div_neg;
        if (cmd.md_latch) mean_reg[k_reg] <= q_round;
        if (cmd.p2_diff) d_reg <= DFW'(q_round) - DFW'(mean_reg[k_reg]);
        if (cmd.p2_sqr) sq_reg <= d_reg * d_reg;
        if (cmd.p2_acc) ss_reg[k_reg] <= ss_reg[k_reg] + ACC_W'(sq_reg);
        if (cmd.nn_calc) nn_reg <= n_reg * n_m1;
        if (cmd.err_latch) begin
            err_reg[k_reg] <= (root > (DW/2)'(pgl_pkg::MAX24)) ? pgl_pkg::MAX24
                                                              : root[CW-1:0];
        end
        if (cmd.drift_calc) begin
            dp_prod_reg <= mt_mag * dv_reg;
            de_prod_reg <= err_reg[2] * dv_reg;
        end
        if (cmd.out_load) m_word_reg <= out_next;
    end

    always_comb begin
        mt_mag = mean_reg[2][CW-1] ? CW'(-mean_reg[2]) : CW'(mean_reg[2]);
        dp_sum = dp_prod_reg + PW'(17'h08000);
        de_sum = de_prod_reg + PW'(17'h08000);
        dp_mag = dp_sum[PW-1:16];

        out_next             = '0;
        out_next.line_number = line_reg;
        if (n_reg != '0) begin
            out_next.hit_total = (n_reg > N_W'(pgl_pkg::MAX24)) ? pgl_pkg::MAX24
                                                                : n_reg[CW-1:0];
            out_next.has_hits  = 1'b1;
            out_next.mean_z    = mean_reg[0];
            out_next.mean_y    = mean_reg[1];
            out_next.mean_t    = mean_reg[2];
            out_next.drift_position = mean_reg[2][CW-1] ? -$signed(dp_mag)
                                                        : $signed(dp_mag);
            if (n_reg == N_W'(1)) begin
                out_next.error_z     = pgl_pkg::MAX24;
                out_next.error_y     = pgl_pkg::MAX24;
                out_next.error_t     = pgl_pkg::MAX24;
                out_next.drift_error = pgl_pkg::MAX24;
                out_next.single_hit  = 1'b1;
            end else begin
                out_next.error_z     = err_reg[0];
                out_next.error_y     = err_reg[1];
                out_next.error_t     = err_reg[2];
                out_next.drift_error = de_sum[PW-1:16];
            end
        end
    end

    always_comb begin
        stat.line_ok    = 32'(line_reg) < line_lim;
        stat.pad_last   = cnt_reg == AW'(line_len - 1);
        stat.sweep_last = cnt_reg == AW'(GRID_PADS - 1);
        stat.k_last     = k_reg == 2'(pgl_pkg::NUM_AXES - 1);
        stat.n_zero     = n_reg == '0;
        stat.n_one      = n_reg == N_W'(1);
        stat.pad_empty  = rd_q_reg.count == '0;
        stat.div_done   = div_done;
        stat.sqrt_done  = sqrt_done;
    end

    assign m_word = m_word_reg;

endmodule

// ===== hdl/pgl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pgl_ctrl
// Sequencer for add, clear and report; owns both handshakes.
// ----------------------------------------------------------------------------
module pgl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         in_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    input  pgl_pkg::dp_stat_t  stat,
    output pgl_pkg::dp_cmd_t   cmd
);
    typedef enum logic [19:0] {
        S_CLEAR   = 20'h00001,
        S_IDLE    = 20'h00002,
        S_ADD     = 20'h00004,
        S_P1_RD   = 20'h00008,
        S_P1_ACC  = 20'h00010,
        S_MD_GO   = 20'h00020,
        S_MD_WAIT = 20'h00040,
        S_P2_RD   = 20'h00080,
        S_P2_CHK  = 20'h00100,
        S_P2_GO   = 20'h00200,
        S_P2_WAIT = 20'h00400,
        S_P2_SQR  = 20'h00800,
        S_P2_ACC  = 20'h01000,
        S_NN      = 20'h02000,
        S_ED_GO   = 20'h04000,
        S_ED_WAIT = 20'h08000,
        S_SQ_GO   = 20'h10000,
        S_SQ_WAIT = 20'h20000,
        S_DRIFT   = 20'h40000,
        S_FIN     = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (in_cmd)
                        pgl_pkg::CMD_ADD: begin
                            cmd.rd_hit = 1'b1;
                            state_next = S_ADD;
                        end
                        pgl_pkg::CMD_REPORT: state_next = S_P1_RD;
                        pgl_pkg::CMD_CLEAR:  state_next = S_CLEAR;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                cmd.wr_hit = 1'b1;
                state_next = S_IDLE;
            end
            S_P1_RD: begin
                if (!stat.line_ok) begin
                    state_next = S_FIN;
                end else begin
                    cmd.rd_line = 1'b1;
                    state_next  = S_P1_ACC;
                end
            end
            S_P1_ACC: begin
                cmd.p1_acc    = 1'b1;
                cmd.step_line = 1'b1;
                state_next    = stat.pad_last ? S_MD_GO : S_P1_RD;
            end
            S_MD_GO: begin
                if (stat.n_zero) begin
                    state_next = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pgl_pkg::DIV_MEAN;
                    state_next    = S_MD_WAIT;
                end
            end
            S_MD_WAIT: begin
                cmd.div_sel = pgl_pkg::DIV_MEAN;
                if (stat.div_done) begin
                    cmd.md_latch = 1'b1;
                    if (stat.k_last) begin
                        cmd.k_clr  = 1'b1;
                        state_next = S_P2_RD;
                    end else begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_MD_GO;
                    end
                end
            end
            S_P2_RD: begin
                cmd.rd_line = 1'b1;
                state_next  = S_P2_CHK;
            end
            S_P2_CHK: begin
                if (stat.pad_empty) begin
                    cmd.step_line = 1'b1;
                    state_next    = stat.pad_last ? S_NN : S_P2_RD;
                end else begin
                    state_next = S_P2_GO;
                end
            end
            S_P2_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = pgl_pkg::DIV_PAD;
                state_next    = S_P2_WAIT;
            end
            S_P2_WAIT: begin
                cmd.div_sel = pgl_pkg::DIV_PAD;
                if (stat.div_done) begin
                    cmd.p2_diff = 1'b1;
                    state_next  = S_P2_SQR;
                end
            end
            S_P2_SQR: begin
                cmd.p2_sqr = 1'b1;
                state_next = S_P2_ACC;
            end
            S_P2_ACC: begin
                cmd.p2_acc = 1'b1;
                if (stat.k_last) begin
                    cmd.k_clr     = 1'b1;
                    cmd.step_line = 1'b1;
                    state_next    = stat.pad_last ? S_NN : S_P2_RD;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_P2_GO;
                end
            end
            S_NN: begin
                if (stat.n_one) begin
                    state_next = S_DRIFT;
                end else begin
                    cmd.nn_calc = 1'b1;
                    state_next  = S_ED_GO;
                end
            end
            S_ED_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = pgl_pkg::DIV_ERR;
                state_next    = S_ED_WAIT;
            end
            S_ED_WAIT: begin
                cmd.div_sel = pgl_pkg::DIV_ERR;
                if (stat.div_done) state_next = S_SQ_GO;
            end
            S_SQ_GO: begin
                cmd.sq_start = 1'b1;
                state_next   = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (stat.sqrt_done) begin
                    cmd.err_latch = 1'b1;
                    if (stat.k_last) begin
                        cmd.k_clr  = 1'b1;
                        state_next = S_DRIFT;
                    end else begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_ED_GO;
                    end
                end
            end
            S_DRIFT: begin
                cmd.drift_calc = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        if (cmd.out_load) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;

endmodule

// ===== hdl/pad_grid_line_centroid.sv =====
// ----------------------------------------------------------------------------
// pad_grid_line_centroid
// Add hit: pad memory read, then write back; s_ready is low during the write.
// Clear: one pad per cycle, GRID_PADS pads (9216 at defaults).
// Report: pass one sums the L pads on the line and divides a mean per axis; pass
// two divides each of the P pads with hits, then error division and root per axis.
// Reset: the same clearing pass runs after reset with s_ready low.
// ----------------------------------------------------------------------------
module pad_grid_line_centroid #(
    parameter int PADS_Z_PER_MODULE = pgl_pkg::PADS_Z_DEF,
    parameter int PADS_Y_PER_MODULE = pgl_pkg::PADS_Y_DEF,
    parameter int MODULES_PER_ROW   = pgl_pkg::MODULES_ROW_DEF,
    parameter int MODULE_ROWS       = pgl_pkg::MODULE_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pgl_pkg::in_word_t              s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pgl_pkg::out_word_t             m_word,
    input  logic                           cfg_wr_en,
    input  logic [pgl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pgl_pkg::DV_W-1:0]       cfg_wr_data
);
    pgl_pkg::dp_cmd_t  dp_cmd;
    pgl_pkg::dp_stat_t dp_stat;

    pgl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_cmd  (s_word.command),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    pgl_dpath #(
        .PADS_Z_PER_MODULE (PADS_Z_PER_MODULE),
        .PADS_Y_PER_MODULE (PADS_Y_PER_MODULE),
        .MODULES_PER_ROW   (MODULES_PER_ROW),
        .MODULE_ROWS       (MODULE_ROWS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_word      (s_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .m_word      (m_word)
    );

endmodule

// ===== hdl/pgl_checker.sv =====
// ----------------------------------------------------------------------------
// pgl_checker
// Port-level checks for the pad grid line centroid, bound to the top level.
// ----------------------------------------------------------------------------
module pgl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input pgl_pkg::in_word_t              s_word,
    input logic                           m_valid,
    input logic                           m_ready,
    input pgl_pkg::out_word_t             m_word
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word dropped or changed while stalled");

    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during clearing pass");

    a_add_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && s_word.command == pgl_pkg::CMD_ADD
        |=> !m_valid)
        else $error("add word produced a result");

    a_report_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_word.command == pgl_pkg::CMD_REPORT |=> !s_ready)
        else $error("input taken while line walk starts");

endmodule

bind pad_grid_line_centroid pgl_checker u_pgl_checker (.*);
